>>> rtl/two_phase_rgb_fade_core_macros.svh
// Assertion macros for the two-phase RGB fade core.
// Expects signals clk and rst_n in the scope of each use; no other dependencies.
`ifndef TWO_PHASE_RGB_FADE_CORE_MACROS_SVH
`define TWO_PHASE_RGB_FADE_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define TPF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TPF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tpf_pkg.sv
// Shared types and constants for the two-phase RGB fade core.
// No dependencies; used by tpf_ctrl, tpf_dp and two_phase_rgb_fade_core.
package tpf_pkg;

  localparam int LEVEL_BITS_DEF = 8;
  localparam int TIME_BITS_DEF  = 16;
  localparam int NUM_CH         = 3;

  // Item kinds carried on tuser
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_COLOUR = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_CHAN,
    ST_NUM,
    ST_DIV,
    ST_EMIT
  } tpf_state_t;

  // Controller to datapath
  typedef struct packed {
    logic       load;   // apply accepted word (command set-up or tick)
    logic       sw;     // enter falling phase
    logic       fin;    // snap to goal, go idle
    logic       mul;    // latch channel and form span * elapsed
    logic       num;    // add rounding term, load divider
    logic       step;   // one divider iteration
    logic       write;  // write interpolated level
    logic [1:0] ch;     // channel under work
  } tpf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic              busy;
    logic              in_phase;  // elapsed below phase length
    logic              split;
    logic              falling;
    logic [NUM_CH-1:0] moves;     // channel moves in current phase
    logic              div_done;
  } tpf_status_t;

endpackage

>>> rtl/tpf_ctrl.sv
// Sequencer for the fade core: walks check, per-channel multiply/divide and emit.
// Depends on tpf_pkg (state enum, command and status structs).
module tpf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic                out_free,
  input  tpf_pkg::tpf_status_t status,
  output logic                in_ready,
  output logic                emit,
  output tpf_pkg::tpf_cmd_t   cmd
);

  localparam logic [1:0] LAST_CH = 2'(tpf_pkg::NUM_CH - 1);

  tpf_pkg::tpf_state_t state_r, state_nxt;
  logic [1:0]          ch_r, ch_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tpf_pkg::ST_IDLE;
      ch_r    <= '0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    ch_nxt    = ch_r;
    unique case (state_r)
      tpf_pkg::ST_IDLE: begin
        if (in_fire) state_nxt = tpf_pkg::ST_CHECK;
      end
      tpf_pkg::ST_CHECK: begin
        if (!status.busy) begin
          state_nxt = tpf_pkg::ST_EMIT;
        end else if (status.in_phase) begin
          ch_nxt    = '0;
          state_nxt = tpf_pkg::ST_CHAN;
        end else if (status.split && !status.falling) begin
          state_nxt = tpf_pkg::ST_CHECK;
        end else begin
          state_nxt = tpf_pkg::ST_EMIT;
        end
      end
      tpf_pkg::ST_CHAN: begin
        if (status.moves[ch_r]) begin
          state_nxt = tpf_pkg::ST_NUM;
        end else if (ch_r == LAST_CH) begin
          state_nxt = tpf_pkg::ST_EMIT;
        end else begin
          ch_nxt = ch_r + 2'd1;
        end
      end
      tpf_pkg::ST_NUM: begin
        state_nxt = tpf_pkg::ST_DIV;
      end
      tpf_pkg::ST_DIV: begin
        if (status.div_done) begin
          if (ch_r == LAST_CH) begin
            state_nxt = tpf_pkg::ST_EMIT;
          end else begin
            ch_nxt    = ch_r + 2'd1;
            state_nxt = tpf_pkg::ST_CHAN;
          end
        end
      end
      tpf_pkg::ST_EMIT: begin
        if (out_free) state_nxt = tpf_pkg::ST_IDLE;
      end
      default: state_nxt = tpf_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    cmd.ch   = ch_r;
    in_ready = 1'b0;
    emit     = 1'b0;
    unique case (state_r)
      tpf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_fire;
      end
      tpf_pkg::ST_CHECK: begin
        if (status.busy && !status.in_phase) begin
          if (status.split && !status.falling) cmd.sw = 1'b1;
          else cmd.fin = 1'b1;
        end
      end
      tpf_pkg::ST_CHAN: begin
        cmd.mul = status.moves[ch_r];
      end
      tpf_pkg::ST_NUM: begin
        cmd.num = 1'b1;
      end
      tpf_pkg::ST_DIV: begin
        if (status.div_done) cmd.write = 1'b1;
        else cmd.step = 1'b1;
      end
      tpf_pkg::ST_EMIT: begin
        emit = out_free;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/tpf_dp.sv
// Fade datapath: colour state, span * elapsed multiplier and a shared
// one-bit-per-cycle restoring divider. Depends on tpf_pkg.
module tpf_dp #(
  parameter int LEVEL_BITS = tpf_pkg::LEVEL_BITS_DEF,
  parameter int TIME_BITS  = tpf_pkg::TIME_BITS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  tpf_pkg::tpf_cmd_t                           cmd,
  input  logic                                        in_op,
  input  logic [tpf_pkg::NUM_CH-1:0][LEVEL_BITS-1:0]  in_level,
  input  logic [TIME_BITS-1:0]                        in_fade,
  output tpf_pkg::tpf_status_t                        status,
  output logic [tpf_pkg::NUM_CH-1:0][LEVEL_BITS-1:0]  shown
);

  localparam int NCH   = tpf_pkg::NUM_CH;
  localparam int PW    = LEVEL_BITS + TIME_BITS;
  localparam int CNT_W = $clog2(LEVEL_BITS + 1);

  logic [NCH-1:0][LEVEL_BITS-1:0] start_r, start_nxt;
  logic [NCH-1:0][LEVEL_BITS-1:0] goal_r, goal_nxt;
  logic [NCH-1:0][LEVEL_BITS-1:0] shown_r, shown_nxt;
  logic [TIME_BITS-1:0]           elapsed_r, elapsed_nxt;
  logic [TIME_BITS-1:0]           plen_r, plen_nxt;
  logic                           busy_r, busy_nxt;
  logic                           split_r, split_nxt;
  logic                           falling_r, falling_nxt;

  logic [LEVEL_BITS-1:0] from_r;
  logic                  dir_r;
  logic [PW-1:0]         prod_r;
  logic [TIME_BITS-1:0]  rem_r;
  logic [LEVEL_BITS-1:0] quo_r;
  logic [CNT_W-1:0]      cnt_r;

  logic                  rise_any, fall_any;
  logic [NCH-1:0]        moves;
  logic [LEVEL_BITS-1:0] span;
  logic [PW-1:0]         num;
  logic [TIME_BITS:0]    trial, diff;
  logic                  fits;
  logic [LEVEL_BITS-1:0] level_new;

  always_comb begin
    rise_any = 1'b0;
    fall_any = 1'b0;
    for (int c = 0; c < NCH; c++) begin
      if (in_level[c] > goal_r[c]) rise_any = 1'b1;
      if (in_level[c] < goal_r[c]) fall_any = 1'b1;
      moves[c] = falling_r ? (start_r[c] > goal_r[c]) : (start_r[c] < goal_r[c]);
    end
  end

  // Colour and timing state
  always_comb begin
    start_nxt   = start_r;
    goal_nxt    = goal_r;
    shown_nxt   = shown_r;
    elapsed_nxt = elapsed_r;
    plen_nxt    = plen_r;
    busy_nxt    = busy_r;
    split_nxt   = split_r;
    falling_nxt = falling_r;
    if (cmd.load) begin
      if (in_op == tpf_pkg::OP_COLOUR) begin
        start_nxt   = goal_r;
        goal_nxt    = in_level;
        split_nxt   = rise_any && fall_any;
        falling_nxt = !rise_any;
        plen_nxt    = (rise_any && fall_any) ? (in_fade >> 1) : in_fade;
        elapsed_nxt = '0;
        busy_nxt    = 1'b1;
      end else if (busy_r && (elapsed_r != {TIME_BITS{1'b1}})) begin
        elapsed_nxt = elapsed_r + 1'b1;
      end
    end
    if (cmd.sw) begin
      falling_nxt = 1'b1;
      elapsed_nxt = '0;
    end
    if (cmd.fin) begin
      start_nxt = goal_r;
      shown_nxt = goal_r;
      busy_nxt  = 1'b0;
    end
    if (cmd.write) shown_nxt[cmd.ch] = level_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r   <= '0;
      goal_r    <= '0;
      shown_r   <= '0;
      elapsed_r <= '0;
      plen_r    <= '0;
      busy_r    <= 1'b0;
      split_r   <= 1'b0;
      falling_r <= 1'b0;
    end else begin
      start_r   <= start_nxt;
      goal_r    <= goal_nxt;
      shown_r   <= shown_nxt;
      elapsed_r <= elapsed_nxt;
      plen_r    <= plen_nxt;
      busy_r    <= busy_nxt;
      split_r   <= split_nxt;
      falling_r <= falling_nxt;
    end
  end

  // Interpolation arithmetic; falling channels round the step up
  assign span  = falling_r ? (start_r[cmd.ch] - goal_r[cmd.ch])
                           : (goal_r[cmd.ch] - start_r[cmd.ch]);
  assign num   = prod_r + (dir_r ? PW'(plen_r - 1'b1) : '0);
  assign trial = {rem_r, quo_r[LEVEL_BITS-1]};
  assign diff  = trial - {1'b0, plen_r};
  assign fits  = !diff[TIME_BITS];
  assign level_new = dir_r ? (from_r - quo_r) : (from_r + quo_r);

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      from_r <= start_r[cmd.ch];
      dir_r  <= falling_r;
      prod_r <= PW'(span) * PW'(elapsed_r);
    end
    // Quotient fits LEVEL_BITS, so the upper part already sits below the divisor
    if (cmd.num) begin
      rem_r <= num[PW-1:LEVEL_BITS];
      quo_r <= num[LEVEL_BITS-1:0];
    end else if (cmd.step) begin
      rem_r <= fits ? diff[TIME_BITS-1:0] : trial[TIME_BITS-1:0];
      quo_r <= {quo_r[LEVEL_BITS-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.num) begin
      cnt_r <= CNT_W'(LEVEL_BITS);
    end else if (cmd.step) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_comb begin
    status          = '0;
    status.busy     = busy_r;
    status.in_phase = elapsed_r < plen_r;
    status.split    = split_r;
    status.falling  = falling_r;
    status.moves    = moves;
    status.div_done = (cnt_r == '0);
  end

  assign shown = shown_r;

endmodule

>>> rtl/two_phase_rgb_fade_core.sv
// Channel     | dir | tuser        | tdata (lowest bit up)
// in_*        | in  | opcode       | red_in, green_in, blue_in, fade_ms, zero fill
// out_*       | out | (none)       | red_level, green_level, blue_level, fading, zero fill
//
// One word at a time. An idle tick goes from check straight to emit; otherwise, within a
// phase, each channel is visited in turn and each moving one is multiplied, then divided
// by the one restoring divider shared by the three channels, before the result is emitted.
// Reset (rst_n low, synchronous) clears colours, timing and the output slot.
// Under back-pressure the output register holds its word; the next word waits to emit.
// Depends on tpf_pkg, tpf_ctrl, tpf_dp and two_phase_rgb_fade_core_macros.svh.
`include "two_phase_rgb_fade_core_macros.svh"

module two_phase_rgb_fade_core #(
  parameter int LEVEL_BITS = tpf_pkg::LEVEL_BITS_DEF,
  parameter int TIME_BITS  = tpf_pkg::TIME_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  // red_in, green_in, blue_in, fade_ms, zero fill
  input  logic [((tpf_pkg::NUM_CH*LEVEL_BITS+TIME_BITS+7)/8)*8-1:0] in_tdata,
  input  logic in_tuser,   // opcode
  input  logic in_tvalid,
  output logic in_tready,
  // red_level, green_level, blue_level, fading, zero fill
  output logic [((tpf_pkg::NUM_CH*LEVEL_BITS+1+7)/8)*8-1:0] out_tdata,
  output logic out_tvalid,
  input  logic out_tready
);

  localparam int NCH    = tpf_pkg::NUM_CH;
  localparam int OUT_W  = ((NCH*LEVEL_BITS+1+7)/8)*8;
  localparam int FADE_LO = NCH*LEVEL_BITS;

  tpf_pkg::tpf_cmd_t    cmd;
  tpf_pkg::tpf_status_t status;

  logic                           in_ready;
  logic                           in_fire;
  logic                           emit;
  logic                           out_free;
  logic [NCH-1:0][LEVEL_BITS-1:0] in_level;
  logic [TIME_BITS-1:0]           in_fade;
  logic [NCH-1:0][LEVEL_BITS-1:0] shown;

  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;

  // Unpack the input word
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      in_level[c] = in_tdata[c*LEVEL_BITS +: LEVEL_BITS];
    end
  end
  assign in_fade = in_tdata[FADE_LO +: TIME_BITS];

  assign in_tready = in_ready;
  assign in_fire   = in_tvalid && in_ready;
  // Slot is free when empty or draining this cycle
  assign out_free  = !out_valid_r || out_tready;

  tpf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_free (out_free),
    .status   (status),
    .in_ready (in_ready),
    .emit     (emit),
    .cmd      (cmd)
  );

  tpf_dp #(
    .LEVEL_BITS (LEVEL_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_op    (in_tuser),
    .in_level (in_level),
    .in_fade  (in_fade),
    .status   (status),
    .shown    (shown)
  );

  // Output slot: load on emit, drop once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = OUT_W'({status.busy, shown});
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Checks
  `TPF_ASSERT_NEXT(a_one_word_at_a_time, in_fire, !in_tready, "input taken twice in a row")
  `TPF_ASSERT_SAME(a_emit_into_free_slot, emit, out_free, "result would overwrite a pending word")
  `TPF_ASSERT_NEXT(a_colour_starts_fade, in_fire && (in_tuser == tpf_pkg::OP_COLOUR), status.busy, "colour word did not start a fade")

endmodule

>>> dv/tb_two_phase_rgb_fade_core.sv
// Self-checking testbench for two_phase_rgb_fade_core: streams tick and colour words,
// predicts every result word with its own fade model and compares field by field.
// Depends on tpf_pkg and the two_phase_rgb_fade_core RTL.
module tb_two_phase_rgb_fade_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LVL_W  = tpf_pkg::LEVEL_BITS_DEF;
  localparam int MS_W   = tpf_pkg::TIME_BITS_DEF;
  localparam int IN_W   = ((tpf_pkg::NUM_CH * LVL_W + MS_W + 7) / 8) * 8;
  localparam int OUT_W  = ((tpf_pkg::NUM_CH * LVL_W + 1 + 7) / 8) * 8;
  localparam int RANDOM_WORDS = 1200;
  // Once this few words remain to be sent, both sides stop idling.
  localparam int TAIL_WORDS   = 120;
  // Leave ample slack after the drain.
  localparam int DRAIN_CYCLES = 60;

  // One input word: opcode plus colour command fields.
  typedef struct packed {
    logic             op;
    logic [LVL_W-1:0] red;
    logic [LVL_W-1:0] green;
    logic [LVL_W-1:0] blue;
    logic [MS_W-1:0]  fade;
  } fade_word_t;

  // One result word: levels shown and the fading flag.
  typedef struct packed {
    logic [LVL_W-1:0] red;
    logic [LVL_W-1:0] green;
    logic [LVL_W-1:0] blue;
    logic             fading;
  } shown_t;

  logic             clk;
  logic             rst_n;
  logic [IN_W-1:0]  in_tdata;   // red_in, green_in, blue_in, fade_ms, zero fill
  logic             in_tuser;   // opcode
  logic             in_tvalid;
  logic             in_tready;
  logic [OUT_W-1:0] out_tdata;  // red_level, green_level, blue_level, fading, zero fill
  logic             out_tvalid;
  logic             out_tready;

  two_phase_rgb_fade_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready)
  );

  // Words waiting to be driven, and the levels predicted for accepted words.
  fade_word_t pending_words[$];
  shown_t     level_queue[$];
  int         word_cnt = 0;
  int         err_cnt  = 0;

  // Stimulus-side copy of the goal, so new colours can keep some channels.
  logic [LVL_W-1:0] gen_goal[3] = '{default: '0};

  // Predictor state of the fade engine.
  logic [LVL_W-1:0] fade_from[3] = '{default: '0};
  logic [LVL_W-1:0] fade_to[3]   = '{default: '0};
  logic [LVL_W-1:0] lvl_now[3]   = '{default: '0};
  logic [MS_W-1:0]  ms_done   = '0;
  logic [MS_W-1:0]  half_len  = '0;
  bit               engaged   = 1'b0;
  bit               two_halves = 1'b0;
  bit               down_half = 1'b0;

  // Handshake bookkeeping; in_taken is shared by driver and monitor.
  bit in_taken = 1'b0;
  int in_gap = 0;
  int out_gap = 0;
  int quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Fade predictor
  // ---------------------------------------------------------------------------

  // Linear blend at the current elapsed time: floor for a rise, and the
  // matching ceiling of the drop for a fall, so a rise rounds towards the start and a fall towards the goal.
  function automatic logic [LVL_W-1:0] blend(logic [LVL_W-1:0] a, logic [LVL_W-1:0] b);
    logic [31:0] span;
    if (b >= a) begin
      span = 32'(b - a);
      return a + LVL_W'((span * ms_done) / half_len);
    end
    span = 32'(a - b);
    return a - LVL_W'((span * ms_done + half_len - 1) / half_len);
  endfunction

  // Evaluate the fade; a finished rising half hands over to the falling half
  // within the same word, which is why the loop may run twice.
  task automatic evaluate_fade();
    bit again;
    bit moves;
    again = 1'b1;
    while (again && engaged) begin
      again = 1'b0;
      if (ms_done < half_len) begin
        for (int c = 0; c < 3; c++) begin
          moves = down_half ? (fade_from[c] > fade_to[c]) : (fade_from[c] < fade_to[c]);
          if (moves) lvl_now[c] = blend(fade_from[c], fade_to[c]);
        end
      end else if (two_halves && !down_half) begin
        down_half = 1'b1;
        ms_done   = '0;
        again     = 1'b1;
      end else begin
        for (int c = 0; c < 3; c++) begin
          fade_from[c] = fade_to[c];
          lvl_now[c]   = fade_to[c];
        end
        engaged = 1'b0;
      end
    end
  endtask

  // Apply one accepted word to the model and return the levels it shows.
  task automatic advance_fade(input fade_word_t w, output shown_t lv);
    logic [LVL_W-1:0] goal[3];
    bit rising;
    bit falling;
    goal = '{w.red, w.green, w.blue};
    rising = 1'b0;
    falling = 1'b0;
    if (w.op == tpf_pkg::OP_COLOUR) begin
      // New fade always starts from the previous goal, not the shown level.
      for (int c = 0; c < 3; c++) begin
        fade_from[c] = fade_to[c];
        fade_to[c]   = goal[c];
        if (fade_to[c] > fade_from[c]) rising = 1'b1;
        if (fade_to[c] < fade_from[c]) falling = 1'b1;
      end
      two_halves = rising && falling;
      down_half  = !rising;
      half_len   = two_halves ? (w.fade >> 1) : w.fade;
      ms_done    = '0;
      engaged    = 1'b1;
      evaluate_fade();
    end else if (engaged) begin
      if (ms_done != {MS_W{1'b1}}) ms_done++;
      evaluate_fade();
    end
    lv.red    = lvl_now[0];
    lv.green  = lvl_now[1];
    lv.blue   = lvl_now[2];
    lv.fading = engaged;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Ticks carry random payload bits; the block must ignore them.
  function automatic void push_ticks(int n);
    fade_word_t w;
    for (int i = 0; i < n; i++) begin
      w = fade_word_t'({$urandom, $urandom});
      w.op = tpf_pkg::OP_TICK;
      pending_words.push_back(w);
      word_cnt++;
    end
  endfunction

  function automatic void push_colour(logic [LVL_W-1:0] r, logic [LVL_W-1:0] g,
                                      logic [LVL_W-1:0] b, logic [MS_W-1:0] ms);
    fade_word_t w;
    w.op = tpf_pkg::OP_COLOUR;
    w.red = r;
    w.green = g;
    w.blue = b;
    w.fade = ms;
    pending_words.push_back(w);
    gen_goal = '{r, g, b};
    word_cnt++;
  endfunction

  // Pick a channel level: keep the goal, hit an extreme, or go random.
  function automatic logic [LVL_W-1:0] pick_level(logic [LVL_W-1:0] keep);
    case ($urandom_range(0, 7))
      0, 1: return keep;
      2:    return '0;
      3:    return '1;
      default: return LVL_W'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: launch words and toggle ready at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive
    fade_word_t nxt;
    bit quiet;
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      out_tready <= 1'b0;
    end else begin
      // Quiet stretches, and the tail of the run, carry no idling at all.
      quiet = (quiet_cycles != 0) || (pending_words.size() < TAIL_WORDS);
      if (quiet_cycles != 0) quiet_cycles--;
      else if ($urandom_range(0, 149) == 0) quiet_cycles = $urandom_range(50, 300);

      // Hold a word until it is taken; only then advance or pause.
      if (!in_tvalid || in_taken) begin
        if (in_gap != 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_words.size() == 0) begin
          in_tvalid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 3) == 0) begin
          in_gap = $urandom_range(1, 18) - 1;
          in_tvalid <= 1'b0;
        end else begin
          nxt = pending_words.pop_front();
          in_tdata  <= IN_W'({nxt.fade, nxt.blue, nxt.green, nxt.red});
          in_tuser  <= nxt.op;
          in_tvalid <= 1'b1;
        end
      end

      // Back-pressure the result side in bursts.
      if (out_gap != 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_gap = $urandom_range(1, 18) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on accepted input words, check accepted result words
  // ---------------------------------------------------------------------------
  function automatic void check_field(string fname, logic [LVL_W-1:0] want,
                                      logic [LVL_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk) begin : watch
    fade_word_t w;
    shown_t lv;
    shown_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        w.op    = in_tuser;
        w.red   = in_tdata[0 +: LVL_W];
        w.green = in_tdata[LVL_W +: LVL_W];
        w.blue  = in_tdata[2*LVL_W +: LVL_W];
        w.fade  = in_tdata[3*LVL_W +: MS_W];
        advance_fade(w, lv);
        level_queue.push_back(lv);
      end
      if (out_tvalid && out_tready) begin
        if (level_queue.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual %0h", $time,
                   out_tdata);
          err_cnt++;
        end else begin
          want = level_queue.pop_front();
          check_field("red_level", want.red, out_tdata[0 +: LVL_W]);
          check_field("green_level", want.green, out_tdata[LVL_W +: LVL_W]);
          check_field("blue_level", want.blue, out_tdata[2*LVL_W +: LVL_W]);
          check_field("fading", LVL_W'(want.fading), LVL_W'(out_tdata[3*LVL_W]));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int ms;
    int n;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = tpf_pkg::OP_TICK;
    out_tready = 1'b0;

    // Directed: idle tick, instant set, single-phase fall, single-phase rise,
    // no-change wait, split with zero-length halves, long split fade restarted mid-fade.
    push_ticks(1);
    push_colour(8'hFF, 8'hFF, 8'hFF, 16'd0);
    push_ticks(1);
    push_colour(8'h00, 8'h00, 8'h00, 16'd2);
    push_ticks(3);
    push_colour(8'hFF, 8'h00, 8'h80, 16'd5);
    push_ticks(6);
    push_colour(8'hFF, 8'h00, 8'h80, 16'd2);
    push_ticks(3);
    push_colour(8'h00, 8'hFF, 8'h80, 16'd1);
    push_colour(8'h10, 8'h20, 8'h30, 16'hFFFF);
    push_ticks(1);
    push_colour(8'hF0, 8'h0F, 8'h55, 16'd3);
    push_ticks(4);

    // Random: mostly a colour followed by enough ticks to finish it,
    // sometimes cut short; the rest is loose ticks and stray commands.
    while (word_cnt < RANDOM_WORDS + 25) begin
      if ($urandom_range(0, 99) < 85) begin
        case ($urandom_range(0, 9))
          0:       ms = $urandom_range(0, 65535);
          1, 2:    ms = $urandom_range(25, 120);
          default: ms = $urandom_range(0, 24);
        endcase
        push_colour(pick_level(gen_goal[0]), pick_level(gen_goal[1]),
                    pick_level(gen_goal[2]), MS_W'(ms));
        if (ms > 120) n = $urandom_range(0, 40);
        else if ($urandom_range(0, 9) < 7) n = ms + $urandom_range(0, 3);
        else n = $urandom_range(0, ms);
        push_ticks(n);
      end else if ($urandom_range(0, 1) == 0) begin
        push_ticks($urandom_range(1, 8));
      end else begin
        push_colour(LVL_W'($urandom), LVL_W'($urandom), LVL_W'($urandom), MS_W'($urandom));
      end
    end

    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Drain: every word sent, every expectation met, then let the block settle.
    while (pending_words.size() != 0 || in_tvalid) @(posedge clk);
    while (level_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_cnt == 0) begin
      $display("tb_two_phase_rgb_fade_core OK");
    end else begin
      $display("tb_two_phase_rgb_fade_core NOT OK");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin : watchdog
    #10_000_000;
    $display("tb_two_phase_rgb_fade_core NOT OK");
    $finish;
  end

endmodule
